// ===== hdl/ghbe_pkg.sv =====
package ghbe_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int TIME_BITS     = 48;
    localparam int IDX_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int OCC_W         = 24;
    localparam int SIZE_W        = 14;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int EXTRA_W       = CFG_W + 1;
    localparam int NEWER_W       = ((TIME_BITS > EXTRA_W) ? TIME_BITS : EXTRA_W) + 1;
    localparam int SUM_W         = SIZE_W + CNT_W + 1;
    localparam int REM_W         = ((SUM_W > OCC_W) ? SUM_W : OCC_W) + 2;

    localparam logic [OCC_W-1:0] OCC_MAX = '1;

    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_GRANT  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RTT    = 2'd0,
        CFG_SLOT   = 2'd1,
        CFG_WINDOW = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] ctime;
        logic [SIZE_W-1:0]    size;
        logic                 flag;
    } grant_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_PRUNE_RD,
        ST_PRUNE,
        ST_EST_RD,
        ST_EST,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_item;
        logic append;
        logic prune_start;
        logic prune_step;
        logic est_start;
        logic est_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic do_prune;
        logic prune_hit;
        logic est_empty;
        logic est_more;
        logic out_busy;
    } dp_status_t;

    // ring index a + b, with a below the depth and b at most depth - 1
    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - IDX_W){1'b0}}, a} + {1'b0, b};
        if (s >= (CNT_W + 1)'(HISTORY_DEPTH)) begin
            s = s - (CNT_W + 1)'(HISTORY_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

// ===== hdl/grant_history_backlog_estimator_unit.sv =====
// Operation: a status report goes from acceptance through the backlog walk to the result
// register; a grant record first appends to the ring and, when pruning applies, prunes
// old grants before the walk. The backlog walk reads at most 64 ring entries.
// Throughput: one transaction at a time; the next is taken the cycle after the result
// is registered, and registering waits while the previous result is still held.
// Reset: synchronous, active low; clears configuration, ring pointers and report state.
module grant_history_backlog_estimator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ghbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ghbe_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [ghbe_pkg::TIME_BITS-1:0]    s_event_time,
    input  logic [ghbe_pkg::OCC_W-1:0]        s_occupancy,
    input  logic [ghbe_pkg::SIZE_W-1:0]       s_grant_size,
    input  logic                              s_report_requested,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ghbe_pkg::OCC_W-1:0]        m_remaining_to_serve,
    output logic                              m_report_seen,
    output logic [ghbe_pkg::TIME_BITS-1:0]    m_last_poll_time,
    output logic                              m_history_overflow
);
    import ghbe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // refuse register writes while reset is applied
    assign cfg_ready = aresetn;

    ghbe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ghbe_dp u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .status               (status),
        .cfg_wr               (cfg_valid && cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_opcode             (s_opcode),
        .s_event_time         (s_event_time),
        .s_occupancy          (s_occupancy),
        .s_grant_size         (s_grant_size),
        .s_report_requested   (s_report_requested),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_remaining_to_serve (m_remaining_to_serve),
        .m_report_seen        (m_report_seen),
        .m_last_poll_time     (m_last_poll_time),
        .m_history_overflow   (m_history_overflow)
    );

    // hold off new transactions while one is in progress
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a transaction is in progress");

    a_no_report_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_report_seen |-> m_remaining_to_serve == '0)
        else $error("backlog non-zero before any status report");

    a_result_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("controller not idle after presenting a result");

endmodule

// ===== hdl/ghbe_ctrl.sv =====
module ghbe_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_opcode,
    output logic                  s_ready,
    input  ghbe_pkg::dp_status_t  status,
    output ghbe_pkg::dp_cmd_t     cmd
);
    import ghbe_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_opcode == OP_GRANT) ? ST_APPEND : ST_EST_RD;
                end
            end
            ST_APPEND: begin
                state_next = status.do_prune ? ST_PRUNE_RD : ST_EST_RD;
            end
            ST_PRUNE_RD: begin
                state_next = ST_PRUNE;
            end
            ST_PRUNE: begin
                if (!status.prune_hit) begin
                    state_next = ST_EST_RD;
                end
            end
            ST_EST_RD: begin
                state_next = status.est_empty ? ST_FINISH : ST_EST;
            end
            ST_EST: begin
                if (!status.est_more) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // hold the input off while reset is applied
                s_ready       = aresetn;
                cmd.load_item = s_valid && aresetn;
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
            end
            ST_PRUNE_RD: begin
                cmd.prune_start = 1'b1;
            end
            ST_PRUNE: begin
                cmd.prune_step = status.prune_hit;
            end
            ST_EST_RD: begin
                cmd.est_start = !status.est_empty;
            end
            ST_EST: begin
                cmd.est_step = 1'b1;
            end
            ST_FINISH: begin
                cmd.finish = !status.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/ghbe_dp.sv =====
module ghbe_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ghbe_pkg::dp_cmd_t                 cmd,
    output ghbe_pkg::dp_status_t              status,
    input  logic                              cfg_wr,
    input  logic [ghbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ghbe_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              s_opcode,
    input  logic [ghbe_pkg::TIME_BITS-1:0]    s_event_time,
    input  logic [ghbe_pkg::OCC_W-1:0]        s_occupancy,
    input  logic [ghbe_pkg::SIZE_W-1:0]       s_grant_size,
    input  logic                              s_report_requested,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ghbe_pkg::OCC_W-1:0]        m_remaining_to_serve,
    output logic                              m_report_seen,
    output logic [ghbe_pkg::TIME_BITS-1:0]    m_last_poll_time,
    output logic                              m_history_overflow
);
    import ghbe_pkg::*;

    grant_entry_t ring_mem [HISTORY_DEPTH];
    grant_entry_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    logic [CFG_W-1:0] rtt_reg;
    logic [CFG_W-1:0] slot_reg;
    logic [CFG_W-1:0] window_reg;

    logic [IDX_W-1:0] oldest_reg;
    logic [IDX_W-1:0] oldest_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [OCC_W-1:0]     rep_occ_reg;
    logic [TIME_BITS-1:0] rep_time_reg;
    logic                 rep_valid_reg;
    logic [TIME_BITS-1:0] poll_time_reg;

    grant_entry_t         item_reg;
    logic [TIME_BITS-1:0] th_reg;
    logic                 do_prune_reg;
    logic [EXTRA_W-1:0]   extra_reg;
    logic                 overflow_reg;

    logic [IDX_W-1:0]     ptr_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic signed [SUM_W-1:0] sum_reg;

    logic                 m_valid_reg;
    logic [OCC_W-1:0]     m_remain_reg;
    logic                 m_seen_reg;
    logic [TIME_BITS-1:0] m_poll_reg;
    logic                 m_ovf_reg;

    logic                 full;
    logic [IDX_W-1:0]     oldest_inc;
    logic [IDX_W-1:0]     newest_idx;
    logic [IDX_W-1:0]     ptr_dec;
    logic                 newer;
    logic signed [SUM_W-1:0] delta;
    logic signed [REM_W-1:0] remain;
    logic [OCC_W-1:0]     remain_sat;

    assign full       = (count_reg == CNT_W'(HISTORY_DEPTH));
    assign oldest_inc = idx_add(oldest_reg, CNT_W'(1));
    assign newest_idx = idx_add(oldest_reg, count_reg - CNT_W'(1));
    assign ptr_dec    = (ptr_reg == '0) ? IDX_W'(HISTORY_DEPTH - 1) : ptr_reg - IDX_W'(1);

    // drop the oldest entry first when the ring is full
    assign oldest_next = full ? oldest_inc : oldest_reg;
    assign count_next  = full ? CNT_W'(HISTORY_DEPTH) : count_reg + CNT_W'(1);
    assign wr_addr     = idx_add(oldest_next,
                                 full ? CNT_W'(HISTORY_DEPTH - 1) : count_reg);

    always_comb begin
        rd_addr = oldest_reg;
        if (cmd.prune_step) begin
            rd_addr = oldest_inc;
        end else if (cmd.prune_start) begin
            rd_addr = oldest_reg;
        end else if (cmd.est_start) begin
            rd_addr = newest_idx;
        end else if (cmd.est_step) begin
            rd_addr = ptr_dec;
        end
    end

    // create time + rtt + slot/2 beyond the report time, without wrap
    assign newer = (NEWER_W'(rd_data_reg.ctime) + NEWER_W'(extra_reg))
                   > NEWER_W'(rep_time_reg);
    assign delta = $signed(SUM_W'(rd_data_reg.size)) - $signed(SUM_W'(rd_data_reg.flag));

    assign remain = $signed({{(REM_W - OCC_W){1'b0}}, rep_occ_reg})
                  - $signed({{(REM_W - SUM_W){sum_reg[SUM_W-1]}}, sum_reg});

    always_comb begin
        if (remain < 0) begin
            remain_sat = '0;
        end else if (remain > $signed({{(REM_W - OCC_W){1'b0}}, OCC_MAX})) begin
            remain_sat = OCC_MAX;
        end else begin
            remain_sat = remain[OCC_W-1:0];
        end
    end

    always_comb begin
        status.do_prune  = do_prune_reg;
        status.prune_hit = (count_reg != '0) && (rd_data_reg.ctime < th_reg);
        status.est_empty = !rep_valid_reg || (count_reg == '0);
        status.est_more  = newer && (rem_reg > CNT_W'(1));
        status.out_busy  = m_valid_reg && !m_ready;
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= ring_mem[rd_addr];
        if (cmd.append) begin
            ring_mem[wr_addr] <= item_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rtt_reg    <= '0;
            slot_reg   <= '0;
            window_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_reg_t'(cfg_index))
                CFG_RTT:    rtt_reg    <= cfg_data;
                CFG_SLOT:   slot_reg   <= cfg_data;
                CFG_WINDOW: window_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg    <= '0;
            count_reg     <= '0;
            rep_occ_reg   <= '0;
            rep_time_reg  <= '0;
            rep_valid_reg <= 1'b0;
            poll_time_reg <= '0;
            overflow_reg  <= 1'b0;
            do_prune_reg  <= 1'b0;
            sum_reg       <= '0;
            rem_reg       <= '0;
        end else begin
            if (cmd.load_item) begin
                overflow_reg <= 1'b0;
                sum_reg      <= '0;
                do_prune_reg <= (s_opcode == OP_GRANT)
                                && (s_event_time > TIME_BITS'(window_reg));
                if (s_opcode == OP_REPORT) begin
                    rep_occ_reg   <= s_occupancy;
                    rep_time_reg  <= s_event_time;
                    rep_valid_reg <= 1'b1;
                end
            end
            if (cmd.append) begin
                oldest_reg   <= oldest_next;
                count_reg    <= count_next;
                overflow_reg <= full;
                if (item_reg.flag) begin
                    poll_time_reg <= item_reg.ctime;
                end
            end
            if (cmd.prune_step) begin
                oldest_reg <= oldest_inc;
                count_reg  <= count_reg - CNT_W'(1);
            end
            if (cmd.est_start) begin
                rem_reg <= count_reg;
            end
            if (cmd.est_step && newer) begin
                sum_reg <= sum_reg + delta;
                rem_reg <= rem_reg - CNT_W'(1);
            end
        end
    end

    // item payload and walk pointer carry no reset
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg.ctime <= s_event_time;
            item_reg.size  <= s_grant_size;
            item_reg.flag  <= s_report_requested;
            th_reg         <= s_event_time - TIME_BITS'(window_reg);
            extra_reg      <= EXTRA_W'(rtt_reg) + EXTRA_W'(slot_reg >> 1);
        end
        if (cmd.est_start) begin
            ptr_reg <= newest_idx;
        end else if (cmd.est_step) begin
            ptr_reg <= ptr_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_remain_reg <= remain_sat;
            m_seen_reg   <= rep_valid_reg;
            m_poll_reg   <= poll_time_reg;
            m_ovf_reg    <= overflow_reg;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_remaining_to_serve = m_remain_reg;
    assign m_report_seen        = m_seen_reg;
    assign m_last_poll_time     = m_poll_reg;
    assign m_history_overflow   = m_ovf_reg;

endmodule

// ===== tb/tb_grant_history_backlog_estimator_unit.sv =====
module tb_grant_history_backlog_estimator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ghbe_pkg::*;

    localparam int          PHASES        = 10;
    localparam int          PHASE_ITEMS   = 125;
    localparam int          SETTLE_CYCLES = 2 * HISTORY_DEPTH + 16;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          SCRIPT_LEN    = 21;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [CFG_W-1:0]     CFG_MAX  = '1;

    typedef struct packed {
        logic [OCC_W-1:0]     rem;
        logic                 seen;
        logic [TIME_BITS-1:0] poll;
        logic                 ovf;
    } backlog_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_REGS
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic                 op;
        logic [TIME_BITS-1:0] t;
        logic [OCC_W-1:0]     occ;
        logic [SIZE_W-1:0]    sz;
        logic                 rq;
        logic [CFG_W-1:0]     rtt;
        logic [CFG_W-1:0]     slot;
        logic [CFG_W-1:0]     win;
        logic                 lit;
        backlog_t             want;
    } script_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_opcode;
    logic [TIME_BITS-1:0] s_event_time;
    logic [OCC_W-1:0]     s_occupancy;
    logic [SIZE_W-1:0]    s_grant_size;
    logic                 s_report_requested;
    logic                 m_valid;
    logic                 m_ready;
    logic [OCC_W-1:0]     m_remaining_to_serve;
    logic                 m_report_seen;
    logic [TIME_BITS-1:0] m_last_poll_time;
    logic                 m_history_overflow;

    grant_history_backlog_estimator_unit u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_opcode             (s_opcode),
        .s_event_time         (s_event_time),
        .s_occupancy          (s_occupancy),
        .s_grant_size         (s_grant_size),
        .s_report_requested   (s_report_requested),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_remaining_to_serve (m_remaining_to_serve),
        .m_report_seen        (m_report_seen),
        .m_last_poll_time     (m_last_poll_time),
        .m_history_overflow   (m_history_overflow)
    );

    // shadow of the estimator state
    grant_entry_t         hist [HISTORY_DEPTH];
    int unsigned          hist_head;
    int unsigned          hist_fill;
    logic [OCC_W-1:0]     rpt_occ;
    logic [TIME_BITS-1:0] rpt_time;
    logic                 rpt_held;
    logic [TIME_BITS-1:0] poll_at;
    logic [CFG_W-1:0]     reg_rtt;
    logic [CFG_W-1:0]     reg_slot;
    logic [CFG_W-1:0]     reg_window;

    backlog_t    backlog_q [$];
    bit          no_idle;
    int unsigned errors;
    int unsigned cycles;
    int unsigned n_reports;
    int unsigned n_grants;
    int unsigned n_overflow;
    int unsigned n_floored;
    int unsigned n_saturated;
    int unsigned n_settings;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached, %0d results outstanding", $time,
                     backlog_q.size());
            $display("grant_history_backlog_estimator_unit test failed");
            $finish;
        end
    end

    function automatic logic [TIME_BITS-1:0] rand_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_BITS-1:0];
    endfunction

    // sum grants still in flight at the report time, newest first
    function automatic logic [OCC_W-1:0] backlog_words();
        longint unsigned reach;
        longint unsigned rt;
        longint unsigned gt;
        longint          owed;
        longint          left;
        grant_entry_t    g;
        if (!rpt_held) begin
            return '0;
        end
        reach = reg_rtt;
        reach = reach + (reg_slot >> 1);
        rt    = rpt_time;
        owed  = 0;
        for (int unsigned k = hist_fill; k > 0; k--) begin
            g  = hist[(hist_head + k - 1) % HISTORY_DEPTH];
            gt = g.ctime;
            if (!(rt < reach || gt > rt - reach)) begin
                break;
            end
            owed = owed + g.size;
            owed = owed - g.flag;
        end
        left = rpt_occ;
        left = left - owed;
        if (left < 0) begin
            left = 0;
        end
        if (left > longint'(OCC_MAX)) begin
            left = OCC_MAX;
        end
        return left[OCC_W-1:0];
    endfunction

    function automatic backlog_t apply_item(logic op, logic [TIME_BITS-1:0] t,
                                            logic [OCC_W-1:0] occ, logic [SIZE_W-1:0] sz,
                                            logic rq);
        backlog_t             r;
        logic [TIME_BITS-1:0] cutoff;
        r.ovf = 1'b0;
        if (op == OP_REPORT) begin
            rpt_occ  = occ;
            rpt_time = t;
            rpt_held = 1'b1;
        end else begin
            // full ring: drop the oldest grant before appending
            if (hist_fill >= HISTORY_DEPTH) begin
                hist_head = (hist_head + 1) % HISTORY_DEPTH;
                hist_fill = HISTORY_DEPTH - 1;
                r.ovf     = 1'b1;
            end
            hist[(hist_head + hist_fill) % HISTORY_DEPTH] = '{ctime: t, size: sz, flag: rq};
            hist_fill++;
            if (t > reg_window) begin
                cutoff = t - reg_window;
                while (hist_fill > 0 && hist[hist_head].ctime < cutoff) begin
                    hist_head = (hist_head + 1) % HISTORY_DEPTH;
                    hist_fill--;
                end
            end
            if (rq) begin
                poll_at = t;
            end
        end
        r.rem  = backlog_words();
        r.seen = rpt_held;
        r.poll = poll_at;
        return r;
    endfunction

    function automatic script_row_t put(logic op, logic [TIME_BITS-1:0] t,
                                        logic [OCC_W-1:0] occ, logic [SIZE_W-1:0] sz,
                                        logic rq);
        script_row_t row;
        row      = '0;
        row.kind = ROW_ITEM;
        row.op   = op;
        row.t    = t;
        row.occ  = occ;
        row.sz   = sz;
        row.rq   = rq;
        return row;
    endfunction

    function automatic script_row_t put_chk(logic op, logic [TIME_BITS-1:0] t,
                                            logic [OCC_W-1:0] occ, logic [SIZE_W-1:0] sz,
                                            logic rq, logic [OCC_W-1:0] rem, logic seen,
                                            logic [TIME_BITS-1:0] poll, logic ovf);
        script_row_t row;
        row      = put(op, t, occ, sz, rq);
        row.lit  = 1'b1;
        row.want = '{rem: rem, seen: seen, poll: poll, ovf: ovf};
        return row;
    endfunction

    function automatic script_row_t set_regs(logic [CFG_W-1:0] rtt, logic [CFG_W-1:0] slot,
                                             logic [CFG_W-1:0] win);
        script_row_t row;
        row      = '0;
        row.kind = ROW_REGS;
        row.rtt  = rtt;
        row.slot = slot;
        row.win  = win;
        return row;
    endfunction

    task automatic wait_drained();
        while (backlog_q.size() != 0) @(posedge aclk);
    endtask

    // leaves cfg_valid high so that writes can run back to back
    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        case (idx)
            CFG_RTT:    reg_rtt    = value;
            CFG_SLOT:   reg_slot   = value;
            CFG_WINDOW: reg_window = value;
            default:    ;
        endcase
    endtask

    task automatic program_regs(logic [CFG_W-1:0] rtt, logic [CFG_W-1:0] slot,
                                logic [CFG_W-1:0] win);
        write_reg(CFG_RTT, rtt);
        write_reg(CFG_SLOT, slot);
        write_reg(CFG_WINDOW, win);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic offer_item(logic op, logic [TIME_BITS-1:0] t, logic [OCC_W-1:0] occ,
                              logic [SIZE_W-1:0] sz, logic rq, logic lit, backlog_t want);
        int unsigned gap;
        backlog_t    due;
        if ($urandom_range(0, 39) == 0) begin
            no_idle = !no_idle;
        end
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_opcode           <= op;
        s_event_time       <= t;
        s_occupancy        <= occ;
        s_grant_size       <= sz;
        s_report_requested <= rq;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        due = apply_item(op, t, occ, sz, rq);
        if (lit) begin
            due = want;
        end
        backlog_q = {backlog_q, due};
        if (op == OP_REPORT) n_reports++;
        else n_grants++;
        if (due.ovf) n_overflow++;
        if (due.seen && due.rem == '0) n_floored++;
        if (due.rem == OCC_MAX) n_saturated++;
    endtask

    // result side: random back-pressure, compare against the oldest expectation
    initial begin
        backlog_t    want;
        int unsigned stall;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            if (backlog_q.size() == 0) begin
                $display("%0t: unexpected result transaction, remaining_to_serve %0h",
                         $time, m_remaining_to_serve);
                errors++;
            end else begin
                want = backlog_q[0];
                backlog_q.delete(0);
                if (m_remaining_to_serve !== want.rem) begin
                    $display("%0t: remaining_to_serve expected %0h, got %0h", $time,
                             want.rem, m_remaining_to_serve);
                    errors++;
                end
                if (m_report_seen !== want.seen) begin
                    $display("%0t: report_seen expected %0b, got %0b", $time,
                             want.seen, m_report_seen);
                    errors++;
                end
                if (m_last_poll_time !== want.poll) begin
                    $display("%0t: last_poll_time expected %0h, got %0h", $time,
                             want.poll, m_last_poll_time);
                    errors++;
                end
                if (m_history_overflow !== want.ovf) begin
                    $display("%0t: history_overflow expected %0b, got %0b", $time,
                             want.ovf, m_history_overflow);
                    errors++;
                end
            end
        end
    end

    initial begin
        script_row_t          script [SCRIPT_LEN];
        logic [CFG_W-1:0]     r_rtt;
        logic [CFG_W-1:0]     r_slot;
        logic [CFG_W-1:0]     r_win;
        logic [TIME_BITS-1:0] now;
        logic [TIME_BITS-1:0] t;
        logic [OCC_W-1:0]     occ;
        logic [SIZE_W-1:0]    sz;
        logic                 op;
        logic                 rq;
        int unsigned          roll;
        int unsigned          pick;

        aresetn            <= 1'b0;
        cfg_valid          <= 1'b0;
        cfg_index          <= CFG_RTT;
        cfg_data           <= '0;
        s_valid            <= 1'b0;
        s_opcode           <= OP_REPORT;
        s_event_time       <= '0;
        s_occupancy        <= '0;
        s_grant_size       <= '0;
        s_report_requested <= 1'b0;

        hist_head  = 0;
        hist_fill  = 0;
        rpt_occ    = '0;
        rpt_time   = '0;
        rpt_held   = 1'b0;
        poll_at    = '0;
        reg_rtt    = '0;
        reg_slot   = '0;
        reg_window = '0;
        no_idle    = 1'b0;

        script = '{
            // no report held yet, registers at reset
            put_chk(OP_GRANT, 100, 0, 5, 1'b1, 0, 1'b0, 100, 1'b0),
            put_chk(OP_GRANT, 0, 24'h00ABCD, 14'h3FFF, 1'b0, 0, 1'b0, 100, 1'b0),
            put(OP_REPORT, 0, OCC_MAX, 14'h2AAA, 1'b1),
            // zero-size flagged grant drives the sum negative: saturate
            put(OP_GRANT, 150, OCC_MAX, 0, 1'b1),
            put_chk(OP_REPORT, 150, 0, 0, 1'b0, 0, 1'b1, 150, 1'b0),
            put(OP_REPORT, 149, 0, 0, 1'b1),
            put_chk(OP_REPORT, TIME_MAX, 123, 0, 1'b0, 123, 1'b1, 150, 1'b0),
            put(OP_GRANT, TIME_MAX, 0, 14'h3FFF, 1'b1),
            // threshold beyond the report time, no wrap
            set_regs(CFG_MAX, CFG_MAX, CFG_MAX),
            put(OP_REPORT, 0, 0, 0, 1'b0),
            put(OP_REPORT, 5, OCC_MAX, 0, 1'b0),
            put(OP_GRANT, 1, 0, 0, 1'b0),
            // out-of-order oldest entry stops the prune
            put(OP_GRANT, 48'h1_0000_0000, 0, 14'h1555, 1'b1),
            put(OP_REPORT, 48'h2_0000_0000, 1000, 0, 1'b0),
            // odd slot size: half is truncated, threshold hit exactly
            set_regs(10, 21, 50),
            put(OP_REPORT, 1000, 500, 0, 1'b0),
            put(OP_GRANT, 1000, 0, 100, 1'b0),
            put(OP_GRANT, 985, 0, 7, 1'b1),
            put(OP_GRANT, 980, 0, 9, 1'b0),
            put(OP_REPORT, 1005, 500, 0, 1'b0),
            put(OP_REPORT, 979, 1234, 0, 1'b0)
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_REGS) begin
                s_valid <= 1'b0;
                wait_drained();
                program_regs(script[i].rtt, script[i].slot, script[i].win);
            end else begin
                offer_item(script[i].op, script[i].t, script[i].occ, script[i].sz,
                           script[i].rq, script[i].lit, script[i].want);
            end
        end
        s_valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                // huge window and small times: nothing pruned, the ring overflows
                r_rtt  = 0;
                r_slot = 0;
                r_win  = CFG_MAX;
                now    = $urandom_range(200, 1000);
            end else if (ph == 1) begin
                r_rtt  = CFG_MAX;
                r_slot = CFG_MAX;
                r_win  = 0;
                now    = rand_time();
            end else if (ph == PHASES - 1) begin
                r_rtt  = 0;
                r_slot = 0;
                r_win  = 0;
                now    = rand_time();
            end else if (ph % 3 == 2) begin
                r_rtt  = $urandom;
                r_slot = $urandom;
                r_win  = $urandom;
                now    = rand_time();
            end else begin
                r_rtt  = $urandom_range(0, 300);
                r_slot = $urandom_range(0, 600);
                r_win  = $urandom_range(0, 3000);
                now    = $urandom_range(0, 1) ? rand_time() : $urandom_range(0, 5000);
            end
            wait_drained();
            program_regs(r_rtt, r_slot, r_win);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                now  = now + $urandom_range(0, 20);
                t    = now;
                if (ph != 0 && roll < 8) begin
                    op  = $urandom_range(0, 1);
                    t   = rand_time();
                    occ = OCC_W'($urandom);
                    sz  = SIZE_W'($urandom);
                    rq  = $urandom_range(0, 1);
                end else begin
                    op = (roll < 72) ? OP_GRANT : OP_REPORT;
                    if ($urandom_range(0, 19) == 0) begin
                        t = now - $urandom_range(0, 150);
                    end
                    pick = $urandom_range(0, 19);
                    if (pick < 9) occ = $urandom_range(0, 60000);
                    else if (pick < 12) occ = $urandom_range(0, 40);
                    else if (pick == 12) occ = OCC_MAX;
                    else occ = OCC_W'($urandom);
                    pick = $urandom_range(0, 19);
                    if (pick < 6) sz = $urandom_range(0, 2);
                    else if (pick < 15) sz = $urandom_range(0, 2000);
                    else sz = SIZE_W'($urandom);
                    rq = $urandom_range(0, 1);
                end
                offer_item(op, t, occ, sz, rq, 1'b0, '0);
            end
            s_valid <= 1'b0;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Run covered %0d status reports and %0d grant records under %0d settings.",
                 n_reports, n_grants, n_settings);
        $display("Estimates: %0d ring overflows, %0d floored at zero, %0d saturated.",
                 n_overflow, n_floored, n_saturated);
        if (errors == 0) begin
            $display("grant_history_backlog_estimator_unit test passed");
        end else begin
            $display("grant_history_backlog_estimator_unit test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ghbe_pkg.sv
hdl/ghbe_ctrl.sv
hdl/ghbe_dp.sv
hdl/grant_history_backlog_estimator_unit.sv
tb/tb_grant_history_backlog_estimator_unit.sv
